// File: rtl/bal_pkg.sv
// ----------------------------------------------------------------------------
// bal_pkg: shared types and constants of the bounded array list engine
// Field widths, stream packing, operation and status codes, control states.
// ----------------------------------------------------------------------------
package bal_pkg;

    // field widths fixed by the stream format
    localparam int OP_W      = 3;
    localparam int POS_W     = 7;
    localparam int VAL_IN_W  = 32;
    localparam int VAL_OUT_W = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 7;

    // tdata layout, lowest field first, padded to whole bytes
    localparam int OP_LSB       = 0;
    localparam int POS_LSB      = OP_LSB + OP_W;
    localparam int VAL_IN_LSB   = POS_LSB + POS_W;
    localparam int IN_USED_W    = VAL_IN_LSB + VAL_IN_W;
    localparam int IN_TDATA_W   = ((IN_USED_W + 7) / 8) * 8;
    localparam int OUT_USED_W   = VAL_OUT_W + STATUS_W + COUNT_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_USED_W;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_REMOVE = 3'd1,
        OP_READ   = 3'd2,
        OP_FIRST  = 3'd3,
        OP_LAST   = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_BADIDX = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_RDWAIT = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

endpackage

// File: rtl/bal_ram.sv
// ----------------------------------------------------------------------------
// bal_ram: generic single-clock ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bal_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/bounded_array_list_engine_top.sv
// ----------------------------------------------------------------------------
// bounded_array_list_engine_top: fixed-capacity ordered list in a ram
// Path from the accepting edge to m_tvalid: append, errors and unused codes pass S_DONE;
// read, first, last pass S_RDWAIT then S_DONE; remove passes S_SHIFT then S_DONE, with
// the elements above the position moved down, one element moved per cycle through the
// ram's single read and write port. S_DONE waits until the output register is free;
// the next beat is taken in the cycle after the result is loaded into it.
// The result sits in an output register, so a new beat is taken while it waits.
// Reset (aresetn low, synchronous) empties the list; ram contents are not cleared.
// ----------------------------------------------------------------------------
module bounded_array_list_engine_top
    import bal_pkg::*;
#(
    parameter int LIST_DEPTH  = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [2:0] operation, [9:3] position, [41:10] value_in, rest zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [31:0] value_out, [33:32] status, [40:34] count, [41] is_empty, rest zero
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int AW   = $clog2(LIST_DEPTH);
    localparam int CW   = $clog2(LIST_DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          ptr_reg, ptr_next;
    logic [AW-1:0]          wr_addr_reg, wr_addr_next;
    logic                   pend_reg, pend_next;
    logic [VAL_OUT_W-1:0]   res_val_reg, res_val_next;
    status_t                res_status_reg, res_status_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                   ram_we, ram_re;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata;

    op_t                    in_op;
    logic [POS_W-1:0]       in_pos;
    logic [VAL_IN_W-1:0]    in_val;
    logic                   list_empty, list_full, pos_bad, out_free, shift_issue;
    logic [CW-1:0]          ptr_m1, count_m1;

    assign in_op  = op_t'(s_tdata[OP_LSB +: OP_W]);
    assign in_pos = s_tdata[POS_LSB +: POS_W];
    assign in_val = s_tdata[VAL_IN_LSB +: VAL_IN_W];

    assign list_empty  = (count_reg == '0);
    assign list_full   = (count_reg == CW'(LIST_DEPTH));
    assign pos_bad     = (CMPW'(in_pos) >= CMPW'(count_reg));
    assign out_free    = !m_tvalid_reg || m_tready;
    assign shift_issue = (ptr_reg < count_reg);
    assign ptr_m1      = ptr_reg - 1'b1;
    assign count_m1    = count_reg - 1'b1;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    bal_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (LIST_DEPTH),
        .ADDR_W(AW)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        wr_addr_next    = wr_addr_reg;
        pend_next       = pend_reg;
        res_val_next    = res_val_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[AW-1:0];
        ram_wdata       = VALUE_WIDTH'(in_val);
        ram_re          = 1'b0;
        ram_raddr       = AW'(in_pos);

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    res_val_next    = '0;
                    res_status_next = STAT_OK;
                    state_next      = S_DONE;
                    case (in_op)
                        OP_APPEND: begin
                            if (list_full) begin
                                res_status_next = STAT_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_REMOVE: begin
                            if (list_empty) begin
                                res_status_next = STAT_EMPTY;
                            end else if (pos_bad) begin
                                res_status_next = STAT_BADIDX;
                            end else begin
                                ptr_next   = CW'(in_pos) + 1'b1;
                                pend_next  = 1'b0;
                                state_next = S_SHIFT;
                            end
                        end
                        OP_READ: begin
                            if (pos_bad) begin
                                res_status_next = STAT_BADIDX;
                            end else begin
                                ram_re     = 1'b1;
                                state_next = S_RDWAIT;
                            end
                        end
                        OP_FIRST: begin
                            if (list_empty) begin
                                res_status_next = STAT_EMPTY;
                            end else begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                state_next = S_RDWAIT;
                            end
                        end
                        OP_LAST: begin
                            if (list_empty) begin
                                res_status_next = STAT_EMPTY;
                            end else begin
                                ram_re     = 1'b1;
                                ram_raddr  = count_m1[AW-1:0];
                                state_next = S_RDWAIT;
                            end
                        end
                        default: begin
                            // unused codes leave the list alone
                            res_status_next = STAT_OK;
                        end
                    endcase
                end
            end
            S_RDWAIT: begin
                res_val_next = VAL_OUT_W'(ram_rdata);
                state_next   = S_DONE;
            end
            S_SHIFT: begin
                // read slot ptr, write its data one slot lower in the next cycle
                if (shift_issue) begin
                    ram_re       = 1'b1;
                    ram_raddr    = ptr_reg[AW-1:0];
                    ptr_next     = ptr_reg + 1'b1;
                    wr_addr_next = ptr_m1[AW-1:0];
                end
                pend_next = shift_issue;
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_addr_reg;
                    ram_wdata = ram_rdata;
                end
                if (!shift_issue && !pend_reg) begin
                    count_next = count_m1;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{OUT_PAD_W{1'b0}}, list_empty, COUNT_W'(count_reg),
                                     res_status_reg, res_val_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg        <= ptr_next;
        wr_addr_reg    <= wr_addr_next;
        res_val_reg    <= res_val_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
    end

endmodule
